/* hw/rtl/ptt_pkg.sv */
// Shared types, codes and constants of the periodic task timer table.
package ptt_pkg;

  // Default table depth and fixed field widths.
  localparam int MAX_TASKS_DEF = 16;
  localparam int TASK_W        = 4;
  localparam int COUNT_W       = 5;
  localparam int TIME_W        = 32;
  localparam int CFG_IDX_W     = 2;
  localparam logic [TIME_W-1:0] MARGIN_RESET = 32'd10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERRUN_MARGIN = 2'd2;

  // Command codes.
  typedef enum logic [2:0] {
    FN_SCAN       = 3'd0,
    FN_ENABLE     = 3'd1,
    FN_ENABLE_OFF = 3'd2,
    FN_DISABLE    = 3'd3,
    FN_DELAY      = 3'd4,
    FN_SET_IVL    = 3'd5,
    FN_CATCH_UP   = 3'd6,
    FN_OVERRUN    = 3'd7
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TASK_RD,
    S_TASK_EX,
    S_DONE
  } state_t;

  // Request payload.
  typedef struct packed {
    logic [2:0]        func;
    logic [TASK_W-1:0] task_req;
    logic [TIME_W-1:0] amount;
    logic [TIME_W-1:0] time_now;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic              fired;
    logic [TASK_W-1:0] fired_task;
    logic              overrun;
    logic              last;
  } rsp_t;

  // Configuration register contents.
  typedef struct packed {
    logic [COUNT_W-1:0] task_count;
    logic               relative_mode;
    logic [TIME_W-1:0]  overrun_margin;
  } cfg_t;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic              en;
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] per;
  } ent_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic idle;
    logic rd_pending;
  } sts_t;

endpackage

/* hw/rtl/ptt_if.sv */
// Valid/ready channel interfaces for requests and results.
interface ptt_req_if;
  logic          valid;
  logic          ready;
  ptt_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptt_rsp_if;
  logic          valid;
  logic          ready;
  ptt_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ptt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/ptt_cfg.sv */
// Configuration registers of the periodic task timer table.
module ptt_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ptt_pkg::TIME_W-1:0]        cfg_wdata,
  output ptt_pkg::cfg_t                     cfg
);
  import ptt_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Register write decode; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TASK_COUNT:     cfg_nxt.task_count     = cfg_wdata[COUNT_W-1:0];
        CFG_RELATIVE_MODE:  cfg_nxt.relative_mode  = cfg_wdata[0];
        CFG_OVERRUN_MARGIN: cfg_nxt.overrun_margin = cfg_wdata;
        default:            cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.task_count     <= '0;
      cfg_r.relative_mode  <= 1'b0;
      cfg_r.overrun_margin <= MARGIN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/ptt_ctrl.sv */
// Command sequencer: read-modify-write of table entries, scan walk and result register.
module ptt_ctrl #(
  parameter int MAX_TASKS = ptt_pkg::MAX_TASKS_DEF,
  parameter int IW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  parameter int CW        = $clog2(MAX_TASKS + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ptt_pkg::cfg_t   cfg,
  ptt_req_if.sink         in_req,
  ptt_rsp_if.source       out_rsp,
  output logic            ram_rd_en,
  output logic [IW-1:0]   ram_rd_addr,
  input  ptt_pkg::ent_t   ram_rd_data,
  output logic            ram_wr_en,
  output logic [IW-1:0]   ram_wr_addr,
  output ptt_pkg::ent_t   ram_wr_data,
  output ptt_pkg::sts_t   sts
);
  import ptt_pkg::*;

  state_t                state_r, state_nxt;
  req_t                  cmd_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  s1_vld_r, s1_vld_nxt;
  logic [IW-1:0]         s1_idx_r, s1_idx_nxt;
  logic                  s1_hit_r, s1_hit_nxt;
  logic [MAX_TASKS-1:0]  vld_r, vld_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rsp_t                  out_data_r, out_data_nxt;

  logic [CW-1:0]         n_sat;
  logic                  can_out;
  ent_t                  ent;
  ent_t                  upd;
  logic                  due_hit;
  logic                  fire;
  logic                  in_range;
  logic [IW-1:0]         slot_idx;
  logic [TIME_W-1:0]     ovr_lim;
  logic                  ovr;

  // Count of slots to visit, clamped to the table depth.
  assign n_sat = ({{(32-COUNT_W){1'b0}}, cfg.task_count} > 32'(MAX_TASKS)) ?
                 CW'(MAX_TASKS) : CW'(cfg.task_count);

  // An entry never written reads as all zero.
  assign ent      = s1_hit_r ? ram_rd_data : '0;
  assign due_hit  = ent.en && (cmd_r.time_now >= ent.due);
  assign fire     = s1_vld_r && due_hit && (func_t'(cmd_r.func) == FN_SCAN);
  assign can_out  = !out_valid_r || out_rsp.ready;
  assign slot_idx = IW'(cmd_r.task_req);
  assign in_range = 32'(in_req.data.task_req) < 32'(MAX_TASKS);
  assign ovr_lim  = ent.due - ent.per + cfg.overrun_margin;
  assign ovr      = cmd_r.time_now > ovr_lim;

  // Next state, memory accesses and result loading.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    s1_vld_nxt    = s1_vld_r;
    s1_idx_nxt    = s1_idx_r;
    s1_hit_nxt    = s1_hit_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_data_nxt  = out_data_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = cnt_r[IW-1:0];
    ram_wr_en     = 1'b0;
    ram_wr_addr   = s1_idx_r;
    upd           = ent;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          cnt_nxt    = '0;
          s1_vld_nxt = 1'b0;
          if (func_t'(in_req.data.func) == FN_SCAN ||
              func_t'(in_req.data.func) == FN_CATCH_UP) begin
            state_nxt = S_SCAN;
          end else if (in_range) begin
            state_nxt = S_TASK_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // Hold everything while a fired result cannot be registered.
        if (!(fire && !can_out)) begin
          if (s1_vld_r && due_hit) begin
            if (func_t'(cmd_r.func) == FN_SCAN) begin
              upd.due = cfg.relative_mode ? (cmd_r.time_now + ent.per) : (ent.due + ent.per);
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{fired: 1'b1, fired_task: TASK_W'(s1_idx_r),
                                overrun: 1'b0, last: 1'b0};
            end else begin
              upd.due = cmd_r.time_now;
            end
            ram_wr_en         = 1'b1;
            vld_nxt[s1_idx_r] = 1'b1;
          end
          // Issue the read of the next slot while this one is written back.
          if (cnt_r < n_sat) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cnt_r[IW-1:0];
            s1_vld_nxt  = 1'b1;
            s1_idx_nxt  = cnt_r[IW-1:0];
            s1_hit_nxt  = vld_r[cnt_r[IW-1:0]];
            cnt_nxt     = cnt_r + 1'b1;
          end else begin
            s1_vld_nxt = 1'b0;
            if (!s1_vld_r) begin
              state_nxt = S_DONE;
            end
          end
        end
      end

      S_TASK_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = slot_idx;
        s1_idx_nxt  = slot_idx;
        s1_hit_nxt  = vld_r[slot_idx];
        state_nxt   = S_TASK_EX;
      end

      S_TASK_EX: begin
        if (can_out) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{fired: 1'b0, fired_task: '0, overrun: 1'b0, last: 1'b1};
          unique case (func_t'(cmd_r.func))
            FN_ENABLE: begin
              upd.en  = 1'b1;
              upd.due = cmd_r.time_now;
            end
            FN_ENABLE_OFF: begin
              if (!ent.en) begin
                upd.en  = 1'b1;
                upd.due = cmd_r.time_now;
              end
            end
            FN_DISABLE:  upd.en  = 1'b0;
            FN_DELAY:    upd.due = ent.due + cmd_r.amount;
            FN_SET_IVL:  upd.per = cmd_r.amount;
            FN_OVERRUN:  out_data_nxt.overrun = ovr;
            FN_SCAN, FN_CATCH_UP: upd = ent;
          endcase
          if (func_t'(cmd_r.func) != FN_OVERRUN) begin
            ram_wr_en         = 1'b1;
            vld_nxt[s1_idx_r] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      S_DONE: begin
        if (can_out) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{fired: 1'b0, fired_task: '0, overrun: 1'b0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_wr_data = upd;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      s1_vld_r    <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      s1_vld_r    <= s1_vld_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      cmd_r <= in_req.data;
    end
    s1_idx_r   <= s1_idx_nxt;
    s1_hit_r   <= s1_hit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_req.ready   = (state_r == S_IDLE);
  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.data   = out_data_r;
  assign sts.idle       = (state_r == S_IDLE);
  assign sts.rd_pending = s1_vld_r;

endmodule

/* hw/rtl/periodic_task_timer_table_unit.sv */
// Top level of the periodic task timer table.
// A per-task command reads its slot in S_TASK_RD, then updates it (an overrun query only reads)
// and registers its result in S_TASK_EX; scan and catch-up walk the slots in use, one slot a
// cycle through the table memory's read port while no stalled fired result holds the walk,
// and close in S_DONE. One command at a time: the next request is taken the cycle after the
// last result is registered. Reset (synchronous, active low) clears the sequencer, the
// per-slot valid bits and the configuration; unwritten slots read zero.
module periodic_task_timer_table_unit #(
  parameter int MAX_TASKS = ptt_pkg::MAX_TASKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ptt_pkg::TIME_W-1:0]     cfg_wdata,
  ptt_req_if.sink                        in_req,
  ptt_rsp_if.source                      out_rsp
);
  import ptt_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  cfg_t          cfg;
  sts_t          sts;
  logic          ram_rd_en;
  logic [IW-1:0] ram_rd_addr;
  ent_t          ram_rd_data;
  logic          ram_wr_en;
  logic [IW-1:0] ram_wr_addr;
  ent_t          ram_wr_data;

  // Configuration registers.
  ptt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Task table memory: enable flag, due time and interval per slot.
  ptt_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (MAX_TASKS),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Command sequencer.
  ptt_ctrl #(
    .MAX_TASKS (MAX_TASKS),
    .IW        (IW),
    .CW        (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_req      (in_req),
    .out_rsp     (out_rsp),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .sts         (sts)
  );

`ifndef ASSERT_OFF
  // No table read may still be in flight once the sequencer takes a new request.
  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    sts.idle |-> !sts.rd_pending)
    else $error("table read outstanding while idle");

  // A fired result is never the closing result of a command.
  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.data.fired) |-> !out_rsp.data.last)
    else $error("fired result marked last");

  // The overrun flag only appears on a closing, non-fired result.
  a_overrun_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.data.overrun) |-> (out_rsp.data.last && !out_rsp.data.fired))
    else $error("overrun flag on a non-final result");

  // A taken request makes the sequencer busy, so no request is taken in the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request accepted on consecutive cycles");
`endif

endmodule

/* tb/ptt_timer_scoreboard.sv */
// Scoreboard for the periodic task timer table: tracks the table and checks every result.
module ptt_timer_scoreboard (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ptt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ptt_pkg::TIME_W-1:0]    cfg_wdata,
  ptt_req_if                            req_mon,
  ptt_rsp_if                            rsp_mon,
  output int                            error_count,
  output int                            awaited
);
  timeunit 1ns;
  timeprecision 1ps;
  import ptt_pkg::*;

  localparam int SLOTS = MAX_TASKS_DEF;

  // Shadow copy of the task table and the configuration registers.
  logic              slot_on  [SLOTS];
  logic [TIME_W-1:0] slot_due [SLOTS];
  logic [TIME_W-1:0] slot_ivl [SLOTS];
  logic [COUNT_W-1:0] count_reg;
  logic               rel_mode;
  logic [TIME_W-1:0]  margin_reg;

  // Results still owed by the block, oldest first.
  rsp_t awaited_rsp[$];

  // Applies one command to the shadow table and queues the results it must produce.
  task automatic forecast_results(input req_t r);
    int                i;
    int                n;
    rsp_t              res;
    rsp_t              hit;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] threshold;
    logic [TASK_W-1:0] s;
    now = r.time_now;
    s   = r.task_req;
    // A count above the table depth saturates for scan and catch-up.
    n   = (int'(count_reg) > SLOTS) ? SLOTS : int'(count_reg);
    res = '0;
    res.last = 1'b1;
    case (func_t'(r.func))
      FN_SCAN: begin
        for (i = 0; i < n; i++) begin
          if (slot_on[i] && now >= slot_due[i]) begin
            slot_due[i] = rel_mode ? now + slot_ivl[i] : slot_due[i] + slot_ivl[i];
            hit = '0;
            hit.fired = 1'b1;
            hit.fired_task = TASK_W'(i);
            awaited_rsp.push_back(hit);
          end
        end
      end
      FN_ENABLE: begin
        slot_on[s]  = 1'b1;
        slot_due[s] = now;
      end
      FN_ENABLE_OFF: begin
        if (!slot_on[s]) begin
          slot_on[s]  = 1'b1;
          slot_due[s] = now;
        end
      end
      FN_DISABLE: slot_on[s] = 1'b0;
      FN_DELAY: slot_due[s] = slot_due[s] + r.amount;
      FN_SET_IVL: slot_ivl[s] = r.amount;
      FN_CATCH_UP: begin
        for (i = 0; i < n; i++) begin
          if (slot_on[i] && now >= slot_due[i]) slot_due[i] = now;
        end
      end
      default: begin
        // Overrun query; the threshold wraps at 32 bits.
        threshold   = slot_due[s] - slot_ivl[s] + margin_reg;
        res.overrun = now > threshold;
      end
    endcase
    awaited_rsp.push_back(res);
  endtask

  // Compares one result field and reports a mismatch.
  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      error_count++;
    end
  endtask

  // Everything is sampled at the rising edge, before the block's outputs update.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_on[i]  = 1'b0;
        slot_due[i] = '0;
        slot_ivl[i] = '0;
      end
      count_reg   = '0;
      rel_mode    = 1'b0;
      margin_reg  = MARGIN_RESET;
      error_count = 0;
      awaited_rsp.delete();
    end else begin
      // Register writes; the unused index is ignored.
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TASK_COUNT:     count_reg  = cfg_wdata[COUNT_W-1:0];
          CFG_RELATIVE_MODE:  rel_mode   = cfg_wdata[0];
          CFG_OVERRUN_MARGIN: margin_reg = cfg_wdata;
          default: ;
        endcase
      end
      // Check a result against the oldest one still owed.
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t ns: result with none expected, actual %0h", $time, rsp_mon.data);
          error_count++;
        end else begin
          want = awaited_rsp.pop_front();
          check_field("fired", 32'(want.fired), 32'(rsp_mon.data.fired));
          check_field("fired_task", 32'(want.fired_task), 32'(rsp_mon.data.fired_task));
          check_field("overrun", 32'(want.overrun), 32'(rsp_mon.data.overrun));
          check_field("last", 32'(want.last), 32'(rsp_mon.data.last));
        end
      end
      // Predict the results of a request taken at this edge.
      if (req_mon.valid && req_mon.ready) forecast_results(req_mon.data);
    end
    awaited = awaited_rsp.size();
  end

endmodule

/* tb/periodic_task_timer_table_unit_test.sv */
// Test top of the periodic task timer table: clock, reset, stimulus, idling and verdict.
module periodic_task_timer_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ptt_pkg::*;

  localparam int SLOTS       = MAX_TASKS_DEF;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 55;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;
  localparam int WATCHDOG    = 4000;
  // Register index that the block does not implement.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [TIME_W-1:0]    cfg_wdata;
  int                   error_count;
  int                   awaited;

  // Stimulus state shared with the result-side process.
  bit                steady  = 1'b0;
  bit                hold_rsp = 1'b0;
  bit                held_off = 1'b0;
  int                slots_in_use = 0;
  logic [TIME_W-1:0] now_ms = '0;

  ptt_req_if in_req();
  ptt_rsp_if out_rsp();

  periodic_task_timer_table_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_rsp   (out_rsp)
  );

  ptt_timer_scoreboard u_scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .req_mon     (in_req),
    .rsp_mon     (out_rsp),
    .error_count (error_count),
    .awaited     (awaited)
  );

  always #10 clk = ~clk;

  function automatic req_t mk_cmd(input func_t fn, input int slot,
                                  input logic [TIME_W-1:0] amount,
                                  input logic [TIME_W-1:0] stamp);
    req_t r;
    r.func     = fn;
    r.task_req = TASK_W'(slot);
    r.amount   = amount;
    r.time_now = stamp;
    return r;
  endfunction

  // Offers one request, with an occasional gap first, and returns at the edge it is taken.
  task automatic send_cmd(input req_t r);
    if (!steady && $urandom_range(99) < 38) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.data  <= r;
    do @(posedge clk); while (!in_req.ready);
  endtask

  // Stops offering requests until every owed result has come back.
  task automatic wait_all_results();
    in_req.valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [TIME_W-1:0] count_word, input bit rel,
                            input logic [TIME_W-1:0] margin);
    write_reg(CFG_TASK_COUNT, count_word);
    write_reg(CFG_RELATIVE_MODE, {31'($urandom), rel});
    write_reg(CFG_OVERRUN_MARGIN, margin);
    cfg_we <= 1'b0;
    slots_in_use = (int'(count_word[COUNT_W-1:0]) > SLOTS) ? SLOTS
                                                          : int'(count_word[COUNT_W-1:0]);
  endtask

  // Builds a mostly well-formed command: time moves forward, slots lie in the active range
  // and intervals are short enough for scans to fire; a few commands carry wild values.
  task automatic next_cmd(output req_t r);
    int pick;
    pick = $urandom_range(99);
    now_ms += TIME_W'($urandom_range(12));
    r.time_now = now_ms;
    r.amount   = ($urandom_range(9) == 0) ? '0 : TIME_W'($urandom_range(60, 1));
    if (slots_in_use == 0 || $urandom_range(9) == 0) r.task_req = TASK_W'($urandom);
    else r.task_req = TASK_W'($urandom_range(slots_in_use - 1));
    if (pick < 34)      r.func = FN_SCAN;
    else if (pick < 44) r.func = FN_ENABLE;
    else if (pick < 52) r.func = FN_ENABLE_OFF;
    else if (pick < 58) r.func = FN_DISABLE;
    else if (pick < 65) r.func = FN_DELAY;
    else if (pick < 77) r.func = FN_SET_IVL;
    else if (pick < 84) r.func = FN_CATCH_UP;
    else                r.func = FN_OVERRUN;
    if ($urandom_range(9) == 0) begin
      r.time_now = $urandom;
      r.amount   = $urandom;
    end
  endtask

  // Result side: random stalls, no stalls in the steady phase, and one long hold-off.
  initial begin
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp && !held_off) begin
        out_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end
      out_rsp.ready <= steady || ($urandom_range(99) >= 38);
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG) begin
      @(posedge clk);
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // Stimulus.
  initial begin
    req_t cmd;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_TASK_COUNT;
    cfg_wdata    <= '0;
    in_req.valid <= 1'b0;
    in_req.data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: an empty scan and a query against the reset margin.
    send_cmd(mk_cmd(FN_SCAN, 15, 32'hFFFF_FFFF, 32'd0));
    send_cmd(mk_cmd(FN_OVERRUN, 0, 32'd0, 32'd11));
    wait_all_results();

    // Full table, absolute mode: extremes of interval, delay and time stamp.
    set_config(32'd16, 1'b0, 32'd10);
    send_cmd(mk_cmd(FN_SET_IVL, 0, 32'd100, 32'd0));
    send_cmd(mk_cmd(FN_SET_IVL, 15, 32'hFFFF_FFFF, 32'd0));
    send_cmd(mk_cmd(FN_ENABLE, 0, 32'd0, 32'd1000));
    send_cmd(mk_cmd(FN_ENABLE_OFF, 3, 32'd0, 32'd5));
    send_cmd(mk_cmd(FN_ENABLE_OFF, 0, 32'd0, 32'd7));
    send_cmd(mk_cmd(FN_ENABLE, 15, 32'd0, 32'hFFFF_FFF0));
    send_cmd(mk_cmd(FN_DELAY, 0, 32'hFFFF_FFFF, 32'd0));
    // A delay on a disabled slot still moves its due time.
    send_cmd(mk_cmd(FN_DELAY, 7, 32'd50, 32'd0));
    send_cmd(mk_cmd(FN_OVERRUN, 0, 32'd0, 32'hFFFF_FFFF));
    send_cmd(mk_cmd(FN_SCAN, 0, 32'd0, 32'd998));
    send_cmd(mk_cmd(FN_SCAN, 0, 32'd0, 32'hFFFF_FFFF));
    send_cmd(mk_cmd(FN_CATCH_UP, 0, 32'd0, 32'd2000));
    send_cmd(mk_cmd(FN_DISABLE, 3, 32'd0, 32'd0));
    send_cmd(mk_cmd(FN_OVERRUN, 15, 32'd0, 32'd0));
    send_cmd(mk_cmd(FN_SCAN, 9, 32'h5A5A_A5A5, 32'd0));
    wait_all_results();

    // Count above the table depth, relative mode, largest margin; the unused index too.
    write_reg(CFG_UNUSED_IDX, $urandom);
    set_config(32'hFFFF_FFF4, 1'b1, 32'hFFFF_FFFF);
    send_cmd(mk_cmd(FN_SCAN, 0, 32'd0, 32'd3000));
    send_cmd(mk_cmd(FN_ENABLE, 15, 32'd0, 32'd3000));
    send_cmd(mk_cmd(FN_CATCH_UP, 0, 32'd0, 32'd4000));
    send_cmd(mk_cmd(FN_SCAN, 0, 32'd0, 32'd4000));
    send_cmd(mk_cmd(FN_OVERRUN, 0, 32'd0, 32'd0));
    wait_all_results();

    // Largest count value, zero margin.
    set_config(32'd31, 1'b0, 32'd0);
    send_cmd(mk_cmd(FN_SCAN, 0, 32'd0, 32'hFFFF_FFFF));
    send_cmd(mk_cmd(FN_SET_IVL, 8, 32'd0, 32'd0));
    send_cmd(mk_cmd(FN_OVERRUN, 8, 32'd0, 32'hFFFF_FFFF));
    wait_all_results();

    // Random phases, each with its own register setting.
    now_ms = 32'd5000;
    for (int p = 0; p < PHASES; p++) begin
      wait_all_results();
      case (p)
        0: set_config(32'd16, 1'b0, 32'd10);
        1: set_config(TIME_W'($urandom_range(15, 1)), 1'b1, 32'd0);
        2: set_config({27'($urandom), 5'd31}, 1'b0, 32'hFFFF_FFFF);
        3: set_config(32'd0, 1'b1, $urandom);
        default: set_config(TIME_W'($urandom_range(20)), 1'($urandom_range(1)),
                            ($urandom_range(3) == 0) ? $urandom
                                                     : TIME_W'($urandom_range(40)));
      endcase
      // One phase runs across the wrap of the time stamp.
      if (p == 6) now_ms = 32'hFFFF_FF80;
      steady = (p == 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 8) hold_rsp = 1'b1;
        if (p == 5 && k == 27) wait_all_results();
        next_cmd(cmd);
        send_cmd(cmd);
      end
    end
    steady = 1'b0;

    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    if (error_count == 0 && awaited == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
